// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational implication checked at every edge.
`define VLMM_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define VLMM_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/vlmm_pkg.sv
// ----------------------------------------------------------------------------
// vlmm_pkg
// Types, sizes and register codes for the 3-D local maxima mask.
// ----------------------------------------------------------------------------
`default_nettype none

package vlmm_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int MAX_DEPTH   = 1024;

  // configuration field widths
  localparam int CFG_W_BITS  = 8;
  localparam int CFG_H_BITS  = 8;
  localparam int CFG_D_BITS  = 11;

  // coordinate and dimension widths
  localparam int XW          = $clog2(MAX_WIDTH);
  localparam int YW          = $clog2(MAX_HEIGHT);
  localparam int ZW          = $clog2(MAX_DEPTH);
  localparam int WDW         = $clog2(MAX_WIDTH + 1);
  localparam int HDW         = $clog2(MAX_HEIGHT + 1);
  localparam int DDW         = $clog2(MAX_DEPTH + 1);

  // plane ring and lookahead
  localparam int PLANE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int PAW         = $clog2(PLANE_DEPTH);
  localparam int PSW         = $clog2(PLANE_DEPTH + 1);
  localparam int LW          = $clog2(PLANE_DEPTH + MAX_WIDTH + 3);

  localparam int VOX_BITS    = 16;

  // register map
  localparam int PADDR_BITS  = 4;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  typedef logic signed [VOX_BITS-1:0] voxel_t;

  typedef struct packed {
    voxel_t distance;
    logic   flush;
  } in_word_t;

  typedef struct packed {
    logic is_seed;
    logic last_voxel;
  } out_word_t;

  typedef struct packed {
    logic [WDW-1:0] w;
    logic [HDW-1:0] h;
    logic [DDW-1:0] d;
  } dims_t;

  typedef struct packed {
    logic          push;
    logic          emit;
    logic          last;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [ZW-1:0] cz;
  } meta_t;

  typedef struct packed {
    meta_t          meta;
    voxel_t         val;
    logic [PAW-1:0] pptr;
    logic [XW-1:0]  lptr;
  } stage_t;

  // window taps: [plane][line][voxel], index 0 is the newest
  typedef voxel_t [2:0][2:0][2:0] win_t;

endpackage

`default_nettype wire

// File: rtl/vlmm_ram.sv
// ----------------------------------------------------------------------------
// vlmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vlmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // a read at the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/vlmm_ctrl.sv
// ----------------------------------------------------------------------------
// vlmm_ctrl
// Input position, pending count, mark position and ring pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module vlmm_ctrl import vlmm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     restart,
  input  dims_t    dims,
  input  logic     in_valid,
  input  in_word_t in_data,
  output logic     in_ready,
  output logic     fill_busy,
  output stage_t   s1
);

  logic [XW-1:0]  x_r, x_nxt, ox_r, ox_nxt;
  logic [YW-1:0]  y_r, y_nxt, oy_r, oy_nxt;
  logic [ZW-1:0]  z_r, z_nxt, oz_r, oz_nxt;
  logic [LW-1:0]  pend_r, pend_nxt;
  logic [LW-1:0]  fill_r, fill_nxt;
  logic [PAW-1:0] pptr_r, pptr_nxt;
  logic [XW-1:0]  lptr_r, lptr_nxt;
  stage_t         s1_r, s1_nxt;

  logic [PSW-1:0] plane_sz;
  logic [LW-1:0]  look;
  logic [LW:0]    pend_inc;
  logic           acc, complete, filling;
  logic           push_vox, push_drain, push_fill, push, emit;
  logic           x_end, y_end, z_end, ox_end, oy_end, oz_end, vol_done;

  always_comb begin
    plane_sz = PSW'(PSW'(dims.w) * PSW'(dims.h));
    look     = LW'(plane_sz) + LW'(dims.w) + LW'(1);
    filling  = (fill_r != '0);
    in_ready = en && !filling;
    acc      = in_valid && in_ready;
    complete = (pend_r != '0) && (x_r == '0) && (y_r == '0) && (z_r == '0);

    push_vox   = acc && !in_data.flush && !complete;
    push_drain = acc && complete;
    push_fill  = en && filling;
    push       = push_vox || push_drain || push_fill;
    pend_inc   = {1'b0, pend_r} + (LW+1)'(1);
    emit       = push_drain || (push_vox && (pend_inc > {1'b0, look}));

    x_end  = (WDW'(x_r) == dims.w - WDW'(1));
    y_end  = (HDW'(y_r) == dims.h - HDW'(1));
    z_end  = (DDW'(z_r) == dims.d - DDW'(1));
    ox_end = (WDW'(ox_r) == dims.w - WDW'(1));
    oy_end = (HDW'(oy_r) == dims.h - HDW'(1));
    oz_end = (DDW'(oz_r) == dims.d - DDW'(1));
    vol_done = push_vox && x_end && y_end && z_end;

    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (push_vox) begin
      x_nxt = x_end ? '0 : x_r + XW'(1);
      if (x_end) begin
        y_nxt = y_end ? '0 : y_r + YW'(1);
        if (y_end) begin
          z_nxt = z_end ? '0 : z_r + ZW'(1);
        end
      end
    end

    ox_nxt = ox_r;
    oy_nxt = oy_r;
    oz_nxt = oz_r;
    if (emit) begin
      ox_nxt = ox_end ? '0 : ox_r + XW'(1);
      if (ox_end) begin
        oy_nxt = oy_end ? '0 : oy_r + YW'(1);
        if (oy_end) begin
          oz_nxt = oz_end ? '0 : oz_r + ZW'(1);
        end
      end
    end

    pend_nxt = pend_r;
    if (push_vox && !emit) begin
      pend_nxt = pend_r + LW'(1);
    end else if (push_drain) begin
      pend_nxt = pend_r - LW'(1);
    end

    // small volume: pad the window so the first mark sits at its centre
    fill_nxt = fill_r;
    if (vol_done) begin
      fill_nxt = look - pend_nxt;
    end else if (push_fill) begin
      fill_nxt = fill_r - LW'(1);
    end

    pptr_nxt = pptr_r;
    lptr_nxt = lptr_r;
    if (push) begin
      pptr_nxt = (PSW'(pptr_r) == plane_sz - PSW'(1)) ? '0 : pptr_r + PAW'(1);
      lptr_nxt = (WDW'(lptr_r) == dims.w - WDW'(1)) ? '0 : lptr_r + XW'(1);
    end

    s1_nxt.meta.push = push;
    s1_nxt.meta.emit = emit;
    s1_nxt.meta.last = ox_end && oy_end && oz_end;
    s1_nxt.meta.cx   = ox_r;
    s1_nxt.meta.cy   = oy_r;
    s1_nxt.meta.cz   = oz_r;
    s1_nxt.val       = push_vox ? in_data.distance : '0;
    s1_nxt.pptr      = pptr_r;
    s1_nxt.lptr      = lptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      x_r    <= '0;
      y_r    <= '0;
      z_r    <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      oz_r   <= '0;
      pend_r <= '0;
      fill_r <= '0;
      pptr_r <= '0;
      lptr_r <= '0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
      pend_r <= pend_nxt;
      fill_r <= fill_nxt;
      pptr_r <= pptr_nxt;
      lptr_r <= lptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.meta <= '0;
    end else if (en) begin
      s1_r.meta <= s1_nxt.meta;
    end
    if (en) begin
      s1_r.val  <= s1_nxt.val;
      s1_r.pptr <= s1_nxt.pptr;
      s1_r.lptr <= s1_nxt.lptr;
    end
  end

  assign s1        = s1_r;
  assign fill_busy = filling;

endmodule

`default_nettype wire

// File: rtl/vlmm_window.sv
// ----------------------------------------------------------------------------
// vlmm_window
// Plane and line delay rings and voxel taps forming the 3x3x3 window.
// ----------------------------------------------------------------------------
`default_nettype none

module vlmm_window import vlmm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  stage_t s1,
  output meta_t  meta5,
  output win_t   win
);

  meta_t          m2_r, m3_r, m4_r, m5_r;
  voxel_t         v2_r;
  logic [PAW-1:0] pptr2_r;
  logic [XW-1:0]  lptr2_r, lptr3_r, lptr4_r;
  voxel_t         q1, q2;
  voxel_t         a3 [3];
  voxel_t         v3_r, q13_r;
  voxel_t         a4_r [3];
  voxel_t         r1 [3];
  voxel_t         r2 [3];
  voxel_t         b50_r [3];
  voxel_t         b51_r [3];
  voxel_t         h1_r [3][3];
  voxel_t         h2_r [3][3];
  voxel_t         cur [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_r <= '0;
      m3_r <= '0;
      m4_r <= '0;
      m5_r <= '0;
    end else if (en) begin
      m2_r <= s1.meta;
      m3_r <= m2_r;
      m4_r <= m3_r;
      m5_r <= m4_r;
    end
  end

  // plane delays: each ring holds one plane of words
  vlmm_ram #(.WIDTH(VOX_BITS), .DEPTH(PLANE_DEPTH)) u_plane1 (
    .clk   (clk),
    .we    (en && s1.meta.push),
    .waddr (s1.pptr),
    .wdata (s1.val),
    .re    (en && s1.meta.push),
    .raddr (s1.pptr),
    .rdata (q1)
  );

  vlmm_ram #(.WIDTH(VOX_BITS), .DEPTH(PLANE_DEPTH)) u_plane2 (
    .clk   (clk),
    .we    (en && m2_r.push),
    .waddr (pptr2_r),
    .wdata (q1),
    .re    (en && m2_r.push),
    .raddr (pptr2_r),
    .rdata (q2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r    <= s1.val;
      pptr2_r <= s1.pptr;
      lptr2_r <= s1.lptr;
      v3_r    <= v2_r;
      q13_r   <= q1;
      lptr3_r <= lptr2_r;
      lptr4_r <= lptr3_r;
    end
  end

  assign a3[0] = v3_r;
  assign a3[1] = q13_r;
  assign a3[2] = q2;

  for (genvar i = 0; i < 3; i++) begin : g_plane
    vlmm_ram #(.WIDTH(VOX_BITS), .DEPTH(MAX_WIDTH)) u_line1 (
      .clk   (clk),
      .we    (en && m3_r.push),
      .waddr (lptr3_r),
      .wdata (a3[i]),
      .re    (en && m3_r.push),
      .raddr (lptr3_r),
      .rdata (r1[i])
    );

    vlmm_ram #(.WIDTH(VOX_BITS), .DEPTH(MAX_WIDTH)) u_line2 (
      .clk   (clk),
      .we    (en && m4_r.push),
      .waddr (lptr4_r),
      .wdata (r1[i]),
      .re    (en && m4_r.push),
      .raddr (lptr4_r),
      .rdata (r2[i])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        a4_r[i]  <= a3[i];
        b50_r[i] <= a4_r[i];
        b51_r[i] <= r1[i];
      end
    end

    assign cur[i][0] = b50_r[i];
    assign cur[i][1] = b51_r[i];
    assign cur[i][2] = r2[i];

    for (genvar j = 0; j < 3; j++) begin : g_line
      // advance the voxel taps only on pushed words
      always_ff @(posedge clk) begin
        if (en && m5_r.push) begin
          h1_r[i][j] <= cur[i][j];
          h2_r[i][j] <= h1_r[i][j];
        end
      end

      assign win[i][j][0] = cur[i][j];
      assign win[i][j][1] = h1_r[i][j];
      assign win[i][j][2] = h2_r[i][j];
    end
  end

  assign meta5 = m5_r;

endmodule

`default_nettype wire

// File: rtl/vlmm_judge.sv
// ----------------------------------------------------------------------------
// vlmm_judge
// Neighbour comparison with volume edge masking, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vlmm_judge import vlmm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  dims_t     dims,
  input  meta_t     meta5,
  input  win_t      win,
  output logic      out_valid,
  output out_word_t out_data
);

  logic      xlo, xhi, ylo, yhi, zlo, zhi;
  logic      okx, oky, okz, beat, seed;
  voxel_t    c;
  logic      out_valid_r;
  out_word_t out_data_r;

  always_comb begin
    xlo  = (meta5.cx != '0);
    xhi  = (WDW'(meta5.cx) != dims.w - WDW'(1));
    ylo  = (meta5.cy != '0);
    yhi  = (HDW'(meta5.cy) != dims.h - HDW'(1));
    zlo  = (meta5.cz != '0);
    zhi  = (DDW'(meta5.cz) != dims.d - DDW'(1));
    c    = win[1][1][1];
    beat = 1'b0;
    okx  = 1'b0;
    oky  = 1'b0;
    okz  = 1'b0;
    // tap index 0 is one step ahead, index 2 one step behind
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          okz = (i == 0) ? zhi : ((i == 2) ? zlo : 1'b1);
          oky = (j == 0) ? yhi : ((j == 2) ? ylo : 1'b1);
          okx = (k == 0) ? xhi : ((k == 2) ? xlo : 1'b1);
          if (!(i == 1 && j == 1 && k == 1) && okz && oky && okx &&
              ($signed(win[i][j][k]) > $signed(c))) begin
            beat = 1'b1;
          end
        end
      end
    end
    seed = ($signed(c) > $signed(voxel_t'(0))) && !beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= meta5.push && meta5.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en && meta5.push && meta5.emit) begin
      out_data_r.is_seed    <= seed;
      out_data_r.last_voxel <= meta5.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/volume_local_maxima_mask_top.sv
// ----------------------------------------------------------------------------
// volume_local_maxima_mask_top
// 3-D local maxima mask over a raster voxel stream, 26-neighbourhood.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one voxel word per handshake, x fastest, then y, then z. A word
//           with flush set drains one pending mark once the volume is done.
//   out_* : one mark word per voxel; the mark of voxel m follows voxel
//           m + W*H + W + 1, or the flush words after the last voxel.
//   APB   : volume_width, volume_height, volume_depth at 0x0, 0x4, 0x8.
//           A write to any of them restarts the stream; write only while idle.
// Throughput is one word per cycle while the receiver keeps up and no
// padding runs. An accepted word passes the input register, two plane
// rings, two line rings with registered reads, compare and result register.
// When a volume holds fewer voxels than the lookahead, in_ready drops after
// its last voxel while the window is padded.
// Reset clears positions and counts; the rings need no clearing pass.
// A stalled receiver holds the whole pipeline and in_ready goes low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module volume_local_maxima_mask_top import vlmm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [CFG_W_BITS-1:0] cfg_w_r;
  logic [CFG_H_BITS-1:0] cfg_h_r;
  logic [CFG_D_BITS-1:0] cfg_d_r;
  logic                  wr, restart, en, fill_busy;
  dims_t                 dims;
  stage_t                s1;
  meta_t                 meta5;
  win_t                  win;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    restart = 1'b0;
    if (wr) begin
      unique case (paddr[3:2])
        REG_WIDTH, REG_HEIGHT, REG_DEPTH: restart = 1'b1;
        default:                          restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= CFG_W_BITS'(MAX_WIDTH);
      cfg_h_r <= CFG_H_BITS'(MAX_HEIGHT);
      cfg_d_r <= CFG_D_BITS'(MAX_DEPTH);
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  cfg_w_r <= pwdata[CFG_W_BITS-1:0];
        REG_HEIGHT: cfg_h_r <= pwdata[CFG_H_BITS-1:0];
        REG_DEPTH:  cfg_d_r <= pwdata[CFG_D_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(cfg_w_r);
      REG_HEIGHT: prdata = 32'(cfg_h_r);
      REG_DEPTH:  prdata = 32'(cfg_d_r);
      default:    prdata = '0;
    endcase
  end

  // zero reads as one, anything above the maximum as the maximum
  always_comb begin
    dims.w = (cfg_w_r == '0) ? WDW'(1) :
             ((32'(cfg_w_r) > MAX_WIDTH) ? WDW'(MAX_WIDTH) : WDW'(cfg_w_r));
    dims.h = (cfg_h_r == '0) ? HDW'(1) :
             ((32'(cfg_h_r) > MAX_HEIGHT) ? HDW'(MAX_HEIGHT) : HDW'(cfg_h_r));
    dims.d = (cfg_d_r == '0) ? DDW'(1) :
             ((32'(cfg_d_r) > MAX_DEPTH) ? DDW'(MAX_DEPTH) : DDW'(cfg_d_r));
  end

  assign en = !out_valid || out_ready;

  vlmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .restart   (restart),
    .dims      (dims),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .fill_busy (fill_busy),
    .s1        (s1)
  );

  vlmm_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .s1    (s1),
    .meta5 (meta5),
    .win   (win)
  );

  vlmm_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .dims      (dims),
    .meta5     (meta5),
    .win       (win),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `VLMM_ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `VLMM_ASSERT_IMP(a_fill_blocks_input, fill_busy, !in_ready, "input taken while padding window")
  `VLMM_ASSERT_NXT(a_stall_holds_mark, out_valid && !out_ready && !meta5.emit, out_valid, "mark lost during stall")

endmodule

`default_nettype wire

// File: bench/volume_local_maxima_mask_top_tb.sv
// ----------------------------------------------------------------------------
// volume_local_maxima_mask_top_tb
// Streams small voxel volumes through the seed mask and checks every mark
// word against a predictor of the 26-neighbour local maxima rule. Volumes
// run under several register settings, the extremes among them, with random
// gaps on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module volume_local_maxima_mask_top_tb;
  import vlmm_pkg::*;

  localparam int  HIST_DEPTH  = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  RAND_ITEMS  = 1950;
  localparam int  SETTLE      = 20;

  class seed_scoreboard;
    logic signed [15:0] history [HIST_DEPTH];
    int unsigned        width_reg, height_reg, depth_reg;
    longint             in_x, in_y, in_z, out_pos, pending;
    out_word_t          mark_q [$];
    int                 errors;

    function new();
      foreach (history[i]) history[i] = '0;
      width_reg  = MAX_WIDTH;
      height_reg = MAX_HEIGHT;
      depth_reg  = MAX_DEPTH;
      restart();
    endfunction

    function void restart();
      in_x = 0; in_y = 0; in_z = 0; out_pos = 0; pending = 0;
    endfunction

    function longint dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned v);
      case (idx)
        REG_WIDTH:  width_reg  = v & 8'hFF;
        REG_HEIGHT: height_reg = v & 8'hFF;
        REG_DEPTH:  depth_reg  = v & 11'h7FF;
        default: return;
      endcase
      restart();
    endfunction

    function void give_mark();
      longint    w, h, d, plane, total, m, x, y, z, nx, ny, nz;
      int        centre, nb;
      bit        seed;
      out_word_t mk;
      w = dim(width_reg, MAX_WIDTH);
      h = dim(height_reg, MAX_HEIGHT);
      d = dim(depth_reg, MAX_DEPTH);
      plane = w * h;
      total = plane * d;
      m = out_pos;
      x = m % w;
      y = (m / w) % h;
      z = m / plane;
      centre = history[m % HIST_DEPTH];
      seed = centre > 0;
      for (int dz = -1; dz <= 1; dz++)
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++) begin
            nx = x + dx; ny = y + dy; nz = z + dz;
            if (dx == 0 && dy == 0 && dz == 0) continue;
            if (nx < 0 || ny < 0 || nz < 0 || nx >= w || ny >= h || nz >= d) continue;
            nb = history[(nz * plane + ny * w + nx) % HIST_DEPTH];
            if (nb > centre) seed = 0;
          end
      mk.is_seed    = seed;
      mk.last_voxel = (m + 1 == total);
      mark_q.push_back(mk);
      out_pos = (m + 1 >= total) ? 0 : m + 1;
      if (pending > 0) pending--;
    endfunction

    function void note_word(in_word_t wd);
      longint w, h, d;
      bit     complete;
      w = dim(width_reg, MAX_WIDTH);
      h = dim(height_reg, MAX_HEIGHT);
      d = dim(depth_reg, MAX_DEPTH);
      complete = pending > 0 && in_x == 0 && in_y == 0 && in_z == 0;
      if (wd.flush || complete) begin
        if (complete) give_mark();
        return;
      end
      history[(out_pos + pending) % HIST_DEPTH] = wd.distance;
      pending++;
      in_x++;
      if (in_x >= w) begin
        in_x = 0;
        in_y++;
        if (in_y >= h) begin
          in_y = 0;
          in_z++;
          if (in_z >= d) in_z = 0;
        end
      end
      if (pending > w * h + w + 1) give_mark();
    endfunction

    function void check_mark(out_word_t got);
      out_word_t exp_mk;
      if (mark_q.size() == 0) begin
        if (errors < 10) $display("unexpected mark word %b", got);
        errors++;
        return;
      end
      exp_mk = mark_q.pop_front();
      if (got.is_seed !== exp_mk.is_seed || got.last_voxel !== exp_mk.last_voxel) begin
        if (errors < 10)
          $display("mark mismatch: is_seed exp %b got %b, last_voxel exp %b got %b",
                   exp_mk.is_seed, got.is_seed, exp_mk.last_voxel, got.last_voxel);
        errors++;
      end
    endfunction

    function void close_out();
      if (mark_q.size() != 0) begin
        $display("%0d mark words never arrived", mark_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  psel, penable, pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  seed_scoreboard sb;
  longint         cycles;
  int             rand_count;
  int             marks_taken;
  bit             sender_calm, receiver_calm;

  volume_local_maxima_mask_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (out_valid && out_ready && rst_n) sb.check_mark(out_data);
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL volume_local_maxima_mask_top");
      $finish;
    end
  end

  // tasks start and end at a falling edge
  task automatic send_word(bit flush, logic [15:0] voxel_val);
    int gap;
    if ($urandom_range(0, 49) == 0) sender_calm = ~sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.distance = voxel_val;
    in_data.flush    = flush;
    in_valid         = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(in_data);
    rand_count++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.mark_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, int unsigned v);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [15:0] pick_distance();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 16'hFFFF));
    return 16'($urandom_range(0, 6) - 2);
  endfunction

  task automatic send_volume(bit truncate);
    longint total, n;
    total = sb.dim(sb.width_reg, MAX_WIDTH) * sb.dim(sb.height_reg, MAX_HEIGHT)
          * sb.dim(sb.depth_reg, MAX_DEPTH);
    n = truncate ? $urandom_range(1, int'(total)) : total;
    for (longint i = 0; i < n; i++) begin
      // stray flush inside the volume is ignored
      if (i > 0 && $urandom_range(0, 19) == 0)
        send_word(1'b1, 16'($urandom_range(0, 16'hFFFF)));
      send_word(1'b0, pick_distance());
    end
    if (truncate) return;
    while (sb.pending > 0) begin
      // a voxel offered while draining counts as a flush
      if ($urandom_range(0, 7) == 0) send_word(1'b0, pick_distance());
      else send_word(1'b1, 16'($urandom_range(0, 16'hFFFF)));
    end
    if ($urandom_range(0, 3) == 0) send_word(1'b1, 16'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic run_setting(int unsigned w, int unsigned h, int unsigned d, int vols);
    wait_idle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_DEPTH, d);
    for (int v = 0; v < vols; v++)
      send_volume(v == vols - 1 && $urandom_range(0, 3) == 0);
  endtask

  // receiver: random hold-offs, calm stretches, one long stall
  initial begin
    int  hold;
    bit  long_done;
    long_done = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) receiver_calm = ~receiver_calm;
      hold = receiver_calm ? 0 : $urandom_range(0, 10);
      if (!long_done && marks_taken >= 300) begin
        hold      = 600;
        long_done = 1;
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      marks_taken++;
      @(negedge clk);
    end
  end

  initial begin
    logic [15:0] directed_vals [12];
    sb            = new();
    cycles        = 0;
    rand_count    = 0;
    marks_taken   = 0;
    sender_calm   = 0;
    receiver_calm = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: 3x2x2 volume with extremes, plateaus and misplaced flushes
    directed_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0005,
                      16'h0005, 16'h0005, 16'h0000, 16'h7FFF, 16'h0003, 16'h0001};
    reg_write(REG_WIDTH, 3);
    reg_write(REG_HEIGHT, 2);
    reg_write(REG_DEPTH, 2);
    send_word(1'b1, 16'h1234);
    for (int i = 0; i < 12; i++) begin
      if (i == 5) send_word(1'b1, 16'h0);
      send_word(1'b0, directed_vals[i]);
    end
    send_word(1'b0, 16'h7FFF);
    while (sb.pending > 0) send_word(1'b1, 16'hFFFF);
    send_word(1'b1, 16'h0);

    // extremes of the registers, zero and over-range writes among them
    run_setting(200, 1, 1, 1);
    run_setting(1, 255, 1, 1);
    run_setting(0, 0, 2047, 1);
    run_setting(1, 1, 1, 3);

    while (rand_count < RAND_ITEMS)
      run_setting($urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 6),
                  $urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 3));

    wait_idle();
    sb.close_out();
    if (sb.errors == 0) $display("PASS volume_local_maxima_mask_top");
    else $display("FAIL volume_local_maxima_mask_top");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/vlmm_pkg.sv
rtl/vlmm_ram.sv
rtl/vlmm_ctrl.sv
rtl/vlmm_window.sv
rtl/vlmm_judge.sv
rtl/volume_local_maxima_mask_top.sv
bench/volume_local_maxima_mask_top_tb.sv
